FILE: hdl/bmc_pkg.sv
// Shared types and constants for the binary mask centroid block.
`default_nettype none
package bmc_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Field and state widths
    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 13;
    localparam int COORD_W = 12;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 25;
    localparam int STEP_W  = $clog2(COORD_W);

    // Constants
    localparam logic [PIX_W-1:0]   TARGET_VALUE  = 8'd255;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 13'd640;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX     = WIDTH_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] ROW_LAST      = COORD_W'(MAX_HEIGHT - 1);
    localparam logic [CNT_W-1:0]   HIT_LIMIT     = CNT_W'(MAX_WIDTH * MAX_HEIGHT);

    // Frame record queue
    localparam int REC_DEPTH = 2;
    localparam int REC_PTR_W = $clog2(REC_DEPTH);
    localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] mask_pixel;
        logic             frame_end;
    } t_pixel;

    typedef struct packed {
        logic [COORD_W-1:0] centroid_x;
        logic [COORD_W-1:0] centroid_y;
        logic [CNT_W-1:0]   target_count;
        logic               target_found;
    } t_result;

    // Totals of one finished frame, handed from accumulator to divider
    typedef struct packed {
        logic [SUM_W-1:0] column_sum;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] hit_count;
    } t_frame_rec;

endpackage
`default_nettype wire

FILE: hdl/bmc_front.sv
// Pixel accumulator: tracks raster position and sums target pixel coordinates.
`default_nettype none
module bmc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bmc_pkg::WIDTH_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_pix_accept,
    input  wire bmc_pkg::t_pixel               i_pix,
    output logic                               o_rec_push,
    output bmc_pkg::t_frame_rec                o_rec
);

    logic [bmc_pkg::WIDTH_W-1:0] r_image_width;
    logic [bmc_pkg::COORD_W-1:0] r_col, n_col;
    logic [bmc_pkg::COORD_W-1:0] r_row, n_row;
    logic [bmc_pkg::SUM_W-1:0]   r_col_sum, n_col_sum;
    logic [bmc_pkg::SUM_W-1:0]   r_row_sum, n_row_sum;
    logic [bmc_pkg::CNT_W-1:0]   r_hit_count, n_hit_count;
    logic [bmc_pkg::WIDTH_W-1:0] eff_width;
    logic                        hit;
    logic                        wrap;

    // Clamp the configured width into 1..MAX_WIDTH
    always_comb begin
        if (r_image_width == '0) begin
            eff_width = bmc_pkg::WIDTH_W'(1);
        end else if (r_image_width > bmc_pkg::WIDTH_MAX) begin
            eff_width = bmc_pkg::WIDTH_MAX;
        end else begin
            eff_width = r_image_width;
        end
    end

    // Accumulate this pixel; hits freeze once the count saturates
    assign hit  = (i_pix.mask_pixel == bmc_pkg::TARGET_VALUE) &&
                  (r_hit_count < bmc_pkg::HIT_LIMIT);
    assign wrap = ({1'b0, r_col} + bmc_pkg::WIDTH_W'(1)) >= eff_width;

    always_comb begin
        n_col_sum   = r_col_sum;
        n_row_sum   = r_row_sum;
        n_hit_count = r_hit_count;
        if (hit) begin
            n_col_sum   = r_col_sum + bmc_pkg::SUM_W'(r_col);
            n_row_sum   = r_row_sum + bmc_pkg::SUM_W'(r_row);
            n_hit_count = r_hit_count + bmc_pkg::CNT_W'(1);
        end
    end

    // Raster position; row holds at the last allowed row
    always_comb begin
        n_col = r_col + bmc_pkg::COORD_W'(1);
        n_row = r_row;
        if (wrap) begin
            n_col = '0;
            if (r_row != bmc_pkg::ROW_LAST) begin
                n_row = r_row + bmc_pkg::COORD_W'(1);
            end
        end
    end

    // Frame totals go out on the last pixel
    assign o_rec_push       = i_pix_accept && i_pix.frame_end;
    assign o_rec.column_sum = n_col_sum;
    assign o_rec.row_sum    = n_row_sum;
    assign o_rec.hit_count  = n_hit_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= bmc_pkg::WIDTH_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_col_sum     <= '0;
            r_row_sum     <= '0;
            r_hit_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_image_width <= i_cfg_wdata;
            end
            if (i_pix_accept) begin
                if (i_pix.frame_end) begin
                    r_col       <= '0;
                    r_row       <= '0;
                    r_col_sum   <= '0;
                    r_row_sum   <= '0;
                    r_hit_count <= '0;
                end else begin
                    r_col       <= n_col;
                    r_row       <= n_row;
                    r_col_sum   <= n_col_sum;
                    r_row_sum   <= n_row_sum;
                    r_hit_count <= n_hit_count;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A frame end leaves the accumulators clear
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_push |=> (r_hit_count == '0 && r_col_sum == '0 && r_col == '0))
        else $error("accumulators not cleared after frame end");

    // Column never reaches the effective width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_pix_accept) && !$past(i_cfg_we) |->
            ({1'b0, r_col} < eff_width))
        else $error("column counter out of range");
`endif

endmodule
`default_nettype wire

FILE: hdl/bmc_queue.sv
// Short queue of finished frame records between accumulator and divider.
`default_nettype none
module bmc_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire bmc_pkg::t_frame_rec  i_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output bmc_pkg::t_frame_rec       o_data
);

    bmc_pkg::t_frame_rec r_mem [bmc_pkg::REC_DEPTH];
    logic [bmc_pkg::REC_PTR_W-1:0] r_wr_ptr;
    logic [bmc_pkg::REC_PTR_W-1:0] r_rd_ptr;
    logic [bmc_pkg::REC_CNT_W-1:0] r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == bmc_pkg::REC_CNT_W'(bmc_pkg::REC_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + bmc_pkg::REC_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bmc_pkg::REC_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + bmc_pkg::REC_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - bmc_pkg::REC_CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Fill count matches the pointer distance
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == bmc_pkg::REC_CNT_W'(bmc_pkg::REC_DEPTH)) |->
            (r_wr_ptr == r_rd_ptr))
        else $error("queue count and pointers disagree");
`endif

endmodule
`default_nettype wire

FILE: hdl/bmc_divider.sv
// Divider: turns frame totals into mean column and row, one quotient bit a cycle.
`default_nettype none
module bmc_divider (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rec_empty,
    input  wire bmc_pkg::t_frame_rec  i_rec,
    output logic                      o_rec_pop,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output bmc_pkg::t_result          o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                       r_state;
    logic [bmc_pkg::STEP_W-1:0]   r_step;
    logic [bmc_pkg::CNT_W-1:0]    r_divisor;
    logic [bmc_pkg::CNT_W-1:0]    r_rem_x, n_rem_x;
    logic [bmc_pkg::CNT_W-1:0]    r_rem_y, n_rem_y;
    logic [bmc_pkg::COORD_W-1:0]  r_quo_x, n_quo_x;
    logic [bmc_pkg::COORD_W-1:0]  r_quo_y, n_quo_y;
    logic                         r_out_valid;
    bmc_pkg::t_result             r_out;
    logic [bmc_pkg::CNT_W:0]      trial_x;
    logic [bmc_pkg::CNT_W:0]      trial_y;
    logic                         ge_x;
    logic                         ge_y;
    logic                         slot_free;
    logic                         found;

    // One restoring step for each coordinate; the quotient shifts in below
    assign trial_x = {r_rem_x, r_quo_x[bmc_pkg::COORD_W-1]};
    assign trial_y = {r_rem_y, r_quo_y[bmc_pkg::COORD_W-1]};
    assign ge_x    = trial_x >= {1'b0, r_divisor};
    assign ge_y    = trial_y >= {1'b0, r_divisor};

    always_comb begin
        n_rem_x = ge_x ? bmc_pkg::CNT_W'(trial_x - {1'b0, r_divisor})
                       : bmc_pkg::CNT_W'(trial_x);
        n_rem_y = ge_y ? bmc_pkg::CNT_W'(trial_y - {1'b0, r_divisor})
                       : bmc_pkg::CNT_W'(trial_y);
        n_quo_x = {r_quo_x[bmc_pkg::COORD_W-2:0], ge_x};
        n_quo_y = {r_quo_y[bmc_pkg::COORD_W-2:0], ge_y};
    end

    assign slot_free = !r_out_valid || i_pop;
    assign found     = (r_divisor != '0);
    assign o_rec_pop = (r_state == S_IDLE) && !i_rec_empty;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // Sequencer and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result refills the slot in the cycle its old one is taken
            if (r_state == S_HOLD && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_rec_empty) begin
                        // Mean fits the coordinate width, so the high part
                        // of the sum is already below the divisor
                        r_divisor <= i_rec.hit_count;
                        r_rem_x   <= bmc_pkg::CNT_W'(
                                     i_rec.column_sum[bmc_pkg::SUM_W-1:bmc_pkg::COORD_W]);
                        r_rem_y   <= bmc_pkg::CNT_W'(
                                     i_rec.row_sum[bmc_pkg::SUM_W-1:bmc_pkg::COORD_W]);
                        r_quo_x   <= i_rec.column_sum[bmc_pkg::COORD_W-1:0];
                        r_quo_y   <= i_rec.row_sum[bmc_pkg::COORD_W-1:0];
                        r_step    <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem_x <= n_rem_x;
                    r_rem_y <= n_rem_y;
                    r_quo_x <= n_quo_x;
                    r_quo_y <= n_quo_y;
                    r_step  <= r_step + bmc_pkg::STEP_W'(1);
                    if (r_step == bmc_pkg::STEP_W'(bmc_pkg::COORD_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (slot_free) begin
                        r_out.centroid_x   <= found ? r_quo_x : '0;
                        r_out.centroid_y   <= found ? r_quo_y : '0;
                        r_out.target_count <= r_divisor;
                        r_out.target_found <= found;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Partial remainders stay below a nonzero divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_divisor != '0) |->
            (r_rem_x < r_divisor && r_rem_y < r_divisor))
        else $error("divider remainder out of range");

    // A waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

FILE: hdl/binary_mask_centroid_unit.sv
// Top level of the binary mask centroid block.
`default_nettype none
// Pixels of a binary mask enter in raster order, one item per clock while full
// is low, and the column and row are tracked from the image width register (a
// width of 0 acts as 1, above 4096 as 4096). Only pixels equal to 255 count. On
// the item that carries frame_end the frame totals move into a two-entry queue
// and the accumulators clear at once, so the next frame starts on the next clock.
// A shared-step divider then produces both mean coordinates for each frame: it
// loads a record from the queue, shifts out the 12 quotient bits one by one, and
// writes the result register. full rises only while both queue entries hold
// pending frames: when short frames arrive faster than the divider drains them,
// or when a finished result waits unread and the divider holds.
module binary_mask_centroid_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bmc_pkg::WIDTH_W-1:0]   i_cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire bmc_pkg::t_pixel               i_pixel,
    output logic                               empty,
    input  wire logic                          pop,
    output bmc_pkg::t_result                   o_result
);

    logic                rec_push;
    bmc_pkg::t_frame_rec rec_in;
    logic                rec_full;
    logic                rec_pop;
    logic                rec_empty;
    bmc_pkg::t_frame_rec rec_out;
    logic                pix_accept;

    assign full       = rec_full;
    assign pix_accept = push && !rec_full;

    // Accumulator
    bmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix_accept (pix_accept),
        .i_pix        (i_pixel),
        .o_rec_push   (rec_push),
        .o_rec        (rec_in)
    );

    // Pending frame totals
    bmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (rec_pop),
        .o_empty (rec_empty),
        .o_data  (rec_out)
    );

    // Mean computation and result register
    bmc_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (rec_empty),
        .i_rec       (rec_out),
        .o_rec_pop   (rec_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

FILE: dv/tb_binary_mask_centroid_unit.sv
// Self-checking testbench for the binary mask centroid unit: directed table, then random frames.
`default_nettype none
module tb_binary_mask_centroid_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int SETTLE_WAIT  = 40;    // two queued frames through the divider, plus margin
    localparam int RANDOM_ITEMS = 1126;
    localparam int HOLD_CYCLES  = 300;

    localparam bmc_pkg::t_result EMPTY_FRAME = '{12'd0, 12'd0, 25'd0, 1'b0};

    // One row of the directed table; a negative width means no register write
    typedef struct {
        int               width_before;
        bmc_pkg::t_pixel  pix;
        bit               has_lit;
        bmc_pkg::t_result lit;
    } t_dir_row;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [bmc_pkg::WIDTH_W-1:0]   cfg_wdata   = '0;
    logic                          push        = 1'b0;
    logic                          full;
    bmc_pkg::t_pixel               i_pixel     = '0;
    logic                          empty;
    logic                          pop         = 1'b0;
    bmc_pkg::t_result              o_result;

    // Predictor state
    logic [bmc_pkg::WIDTH_W-1:0]   width_reg   = bmc_pkg::WIDTH_RESET;
    logic [bmc_pkg::COORD_W-1:0]   col_pos     = '0;
    logic [bmc_pkg::COORD_W-1:0]   row_pos     = '0;
    logic [bmc_pkg::SUM_W-1:0]     col_sum     = '0;
    logic [bmc_pkg::SUM_W-1:0]     row_sum     = '0;
    logic [bmc_pkg::CNT_W-1:0]     hit_total   = '0;

    bmc_pkg::t_result     centroid_exp_q[$];
    int                   err_count     = 0;
    int                   cycle_count   = 0;
    bit                   tx_idle       = 1'b1;
    bit                   rx_idle       = 1'b1;
    int                   rx_hold_cycles = 0;

    t_dir_row dir_rows [24] = '{
        '{-1,   '{8'd0,   1'b1}, 1'b1, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd0, 12'd0, 25'd1, 1'b1}},
        '{-1,   '{8'd254, 1'b1}, 1'b1, EMPTY_FRAME},
        '{-1,   '{8'd127, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd128, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd2, 12'd0, 25'd2, 1'b1}},
        // one pixel per row
        '{1,    '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd0, 12'd1, 25'd4, 1'b1}},
        // zero width behaves as one
        '{0,    '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd0,   1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd0, 12'd1, 25'd2, 1'b1}},
        // oversize width clamps to the maximum, then the maximum width itself
        '{8191, '{8'd1,   1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd1, 12'd0, 25'd2, 1'b1}},
        '{4096, '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd2,   1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b1, '{12'd1, 12'd0, 25'd2, 1'b1}},
        // two-pixel rows, result from the predictor
        '{2,    '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b0}, 1'b0, EMPTY_FRAME},
        '{-1,   '{8'd255, 1'b1}, 1'b0, EMPTY_FRAME}
    };

    binary_mask_centroid_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Accumulate one pixel; returns 1 with the frame result on a frame end
    function automatic bit predict_pixel(input bmc_pkg::t_pixel p,
                                         output bmc_pkg::t_result r);
        int eff_w;
        r = EMPTY_FRAME;
        if (p.mask_pixel == bmc_pkg::TARGET_VALUE && hit_total < bmc_pkg::HIT_LIMIT) begin
            col_sum   = col_sum + bmc_pkg::SUM_W'(col_pos);
            row_sum   = row_sum + bmc_pkg::SUM_W'(row_pos);
            hit_total = hit_total + bmc_pkg::CNT_W'(1);
        end
        if (p.frame_end) begin
            if (hit_total != 0) begin
                r.centroid_x   = bmc_pkg::COORD_W'(col_sum / hit_total);
                r.centroid_y   = bmc_pkg::COORD_W'(row_sum / hit_total);
                r.target_count = hit_total;
                r.target_found = 1'b1;
            end
            col_pos   = '0;
            row_pos   = '0;
            col_sum   = '0;
            row_sum   = '0;
            hit_total = '0;
            return 1'b1;
        end
        if (width_reg == 0)
            eff_w = 1;
        else if (int'(width_reg) > bmc_pkg::MAX_WIDTH)
            eff_w = bmc_pkg::MAX_WIDTH;
        else
            eff_w = int'(width_reg);
        if (int'(col_pos) + 1 >= eff_w) begin
            col_pos = '0;
            if (int'(row_pos) + 1 < bmc_pkg::MAX_HEIGHT)
                row_pos = row_pos + bmc_pkg::COORD_W'(1);
        end else begin
            col_pos = col_pos + bmc_pkg::COORD_W'(1);
        end
        return 1'b0;
    endfunction

    // Offer one item and wait until it is taken
    task automatic send_pixel(input bmc_pkg::t_pixel p, input bit use_lit,
                              input bmc_pkg::t_result lit);
        int               gap;
        bmc_pkg::t_result r;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (predict_pixel(p, r))
            centroid_exp_q.push_back(use_lit ? lit : r);
    endtask

    // Stop offering and let every pending frame come out
    task automatic drain_frames();
        push <= 1'b0;
        while (centroid_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [bmc_pkg::WIDTH_W-1:0] w);
        drain_frames();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        width_reg = w;
    endtask

    function automatic logic [bmc_pkg::WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd2;
            3:       return 13'd4095;
            4:       return 13'd4096;
            5:       return 13'd8191;
            6:       return bmc_pkg::WIDTH_W'($urandom_range(1, 8));
            7, 8:    return bmc_pkg::WIDTH_W'($urandom_range(3, 40));
            default: return bmc_pkg::WIDTH_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // Mostly target or background pixels, some arbitrary values
    function automatic bmc_pkg::t_pixel rand_pixel(input int fe_odds);
        bmc_pkg::t_pixel p;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            p.mask_pixel = bmc_pkg::TARGET_VALUE;
        else if (pick < 75)
            p.mask_pixel = '0;
        else
            p.mask_pixel = bmc_pkg::PIX_W'($urandom_range(0, 255));
        p.frame_end = ($urandom_range(0, fe_odds - 1) == 0);
        return p;
    endfunction

    // Result side: random stalls, one long hold-off on request
    initial begin
        int               stall;
        bmc_pkg::t_result exp_r;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0)
                stall = rx_hold_cycles;
            else
                stall = rx_idle ? $urandom_range(0, 16) : 0;
            rx_hold_cycles = 0;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (centroid_exp_q.size() == 0) begin
                err_count++;
                $error("unexpected result: x %0d y %0d count %0d found %0d",
                       o_result.centroid_x, o_result.centroid_y,
                       o_result.target_count, o_result.target_found);
            end else begin
                exp_r = centroid_exp_q.pop_front();
                if (o_result.centroid_x !== exp_r.centroid_x) begin
                    err_count++;
                    $error("centroid_x: expected %0d, actual %0d",
                           exp_r.centroid_x, o_result.centroid_x);
                end
                if (o_result.centroid_y !== exp_r.centroid_y) begin
                    err_count++;
                    $error("centroid_y: expected %0d, actual %0d",
                           exp_r.centroid_y, o_result.centroid_y);
                end
                if (o_result.target_count !== exp_r.target_count) begin
                    err_count++;
                    $error("target_count: expected %0d, actual %0d",
                           exp_r.target_count, o_result.target_count);
                end
                if (o_result.target_found !== exp_r.target_found) begin
                    err_count++;
                    $error("target_found: expected %0d, actual %0d",
                           exp_r.target_found, o_result.target_found);
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        int rand_items;
        int phase;
        int n;
        int fe_odds;
        rand_items = 0;
        phase      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].width_before >= 0)
                set_width(bmc_pkg::WIDTH_W'(dir_rows[i].width_before));
            send_pixel(dir_rows[i].pix, dir_rows[i].has_lit, dir_rows[i].lit);
        end

        // random phases; a phase may end mid-frame, so width changes land inside frames
        while (rand_items < RANDOM_ITEMS) begin
            phase++;
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            set_width(pick_width());
            n       = $urandom_range(20, 80);
            fe_odds = $urandom_range(2, 24);
            if (phase == 3) begin
                // results back up behind a stalled receiver until the input stalls
                tx_idle        = 1'b0;
                fe_odds        = 1;
                n              = 60;
                rx_hold_cycles = HOLD_CYCLES;
            end
            for (int k = 0; k < n; k++) begin
                send_pixel(rand_pixel(fe_odds), 1'b0, EMPTY_FRAME);
                rand_items++;
            end
        end

        drain_frames();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
